// File: rtl/kwm_pkg.sv
package kwm_pkg;

  localparam int LISTS = 16;
  localparam int DEPTH = 64;

  localparam int OP_W     = 2;
  localparam int LIDX_W   = 4;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;

  localparam int LSEL_W    = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int PTR_W     = $clog2(2 * DEPTH);
  localparam int SLOT_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MEM_DEPTH = LISTS * DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // minimum search: first level reduces groups of lists, second level the groups
  localparam int GRP  = 4;
  localparam int NGRP = (LISTS + GRP - 1) / GRP;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_DROP  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PICK,
    S_POP,
    S_HEAD
  } state_t;

  typedef struct packed {
    logic take;     // latch the input beat
    logic exec;     // run push, clear or no-op and load the result
    logic scan;     // register per-group minimum
    logic pick;     // register overall minimum
    logic pop;      // commit the pop and load the result
    logic head_wr;  // write the refilled head from list memory
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic out_free;
    logic refill;
  } sts_t;

  typedef struct packed {
    logic                    vld;
    logic signed [VAL_W-1:0] val;
    logic [LSEL_W-1:0]       idx;
  } cand_t;

  // keeps a on ties so the lower list index wins when scanned in order
  function automatic cand_t cand_min(input cand_t a, input cand_t b);
    if (b.vld && (!a.vld || ($signed(b.val) < $signed(a.val)))) begin
      return b;
    end
    return a;
  endfunction

  function automatic logic [SLOT_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] s;
    s = (p >= PTR_W'(DEPTH)) ? p - PTR_W'(DEPTH) : p;
    return SLOT_W'(s);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(2 * DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [LSEL_W-1:0] l,
                                                 input logic [SLOT_W-1:0] s);
    return ADDR_W'(int'(l) * DEPTH + int'(s));
  endfunction

endpackage

// File: rtl/kwm_in_if.sv
interface kwm_in_if import kwm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [LIDX_W-1:0]       list_index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output op, output list_index, output value, input ready);
  modport sink (input valid, input op, input list_index, input value, output ready);
endinterface

// File: rtl/kwm_out_if.sv
interface kwm_out_if import kwm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [VAL_W-1:0] out_value;

  modport source (output valid, output status, output out_value, input ready);
  modport sink (input valid, input status, input out_value, output ready);
endinterface

// File: rtl/k_way_sorted_merge_unit.sv
// Merges up to 16 sorted lists held in per-list fifos of 64 entries in one shared
// list memory. Each input beat is a push, pop, clear or no-op and yields exactly one
// result beat. A push, clear or no-op executes once the output register is free.
// A pop passes accept, a per-group minimum over the list heads, the minimum over the
// groups, then commit once that register is free; when the popped list still holds
// entries, its next head is read from the list memory (registered read port) and
// written back in the following cycle, which overlaps the accept of the next beat.
// A result waits in an output register while the next beat is taken. Ties between
// equal heads go to the lower list index. No clearing pass is needed after reset.
module k_way_sorted_merge_unit import kwm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  kwm_in_if.sink    in_if,
  kwm_out_if.source out_if
);

  cmd_t cmd;
  sts_t sts;

  kwm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kwm_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (in_if.op),
    .in_list_index (in_if.list_index),
    .in_value      (in_if.value),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_status    (out_if.status),
    .out_value     (out_if.out_value)
  );

endmodule

// File: rtl/kwm_ram.sv
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/kwm_ctrl.sv
module kwm_ctrl import kwm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.op == OP_POP) begin
          cmd.scan  = 1'b1;
          state_nxt = S_PICK;
        end else if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_POP;
      end
      S_POP: begin
        if (sts.out_free) begin
          cmd.pop   = 1'b1;
          state_nxt = sts.refill ? S_HEAD : S_IDLE;
        end
      end
      S_HEAD: begin
        // next beat may be taken while the new head lands
        cmd.head_wr = 1'b1;
        in_ready    = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_EXEC;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/kwm_dp.sv
module kwm_dp import kwm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic [OP_W-1:0]         in_op,
  input  logic [LIDX_W-1:0]       in_list_index,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     out_status,
  output logic signed [VAL_W-1:0] out_value
);

  op_t                     op_r;
  logic [LIDX_W-1:0]       idx_r;
  logic signed [VAL_W-1:0] val_r;

  logic [PTR_W-1:0]        rd_ptr_r [LISTS];
  logic [PTR_W-1:0]        wr_ptr_r [LISTS];
  logic signed [VAL_W-1:0] head_r   [LISTS];

  cand_t grp_r [NGRP];
  cand_t grp_nxt [NGRP];
  cand_t best_r, best_nxt;

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r;
  logic signed [VAL_W-1:0] out_value_r;

  logic [LSEL_W-1:0] sel;
  logic [PTR_W-1:0]  rp, wp, rp_next, wp_next;
  logic              in_range, sel_empty, sel_full, push_ok, refill, out_free;
  logic              ram_wr_en, ram_rd_en;
  logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
  logic [VAL_W-1:0]  ram_rdata;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r  <= op_t'(in_op);
      idx_r <= in_list_index;
      val_r <= in_value;
    end
  end

  // one list is addressed at a time: the pushed list or the popped one
  assign sel       = cmd.pop ? best_r.idx : LSEL_W'(idx_r);
  assign rp        = rd_ptr_r[sel];
  assign wp        = wr_ptr_r[sel];
  assign rp_next   = ptr_next(rp);
  assign wp_next   = ptr_next(wp);
  assign in_range  = int'(idx_r) < LISTS;
  assign sel_empty = (rp == wp);
  assign sel_full  = !sel_empty && (ptr_slot(rp) == ptr_slot(wp));
  assign push_ok   = (op_r == OP_PUSH) && in_range && !sel_full;
  assign refill    = best_r.vld && (rp_next != wp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LISTS; l++) begin
        rd_ptr_r[l] <= '0;
        wr_ptr_r[l] <= '0;
      end
    end else if (cmd.exec && (op_r == OP_CLEAR)) begin
      for (int l = 0; l < LISTS; l++) begin
        rd_ptr_r[l] <= '0;
        wr_ptr_r[l] <= '0;
      end
    end else begin
      if (cmd.exec && push_ok) begin
        wr_ptr_r[sel] <= wp_next;
      end
      if (cmd.pop && best_r.vld) begin
        rd_ptr_r[sel] <= rp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok && sel_empty) begin
      head_r[sel] <= val_r;
    end
    if (cmd.head_wr) begin
      head_r[best_r.idx] <= $signed(ram_rdata);
    end
  end

  assign ram_wr_en   = cmd.exec && push_ok;
  assign ram_wr_addr = mem_addr(sel, ptr_slot(wp));
  assign ram_rd_en   = cmd.pop && refill;
  assign ram_rd_addr = mem_addr(sel, ptr_slot(rp_next));

  kwm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MEM_DEPTH)
  ) u_list_mem (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (val_r),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rdata)
  );

  // first level: minimum head within each group of lists
  always_comb begin
    cand_t c;
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < LISTS) begin
          c.vld      = rd_ptr_r[g * GRP + k] != wr_ptr_r[g * GRP + k];
          c.val      = head_r[g * GRP + k];
          c.idx      = LSEL_W'(g * GRP + k);
          grp_nxt[g] = cand_min(grp_nxt[g], c);
        end
      end
    end
  end

  // second level: minimum over the groups
  always_comb begin
    best_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      best_nxt = cand_min(best_nxt, grp_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
    if (cmd.pick) begin
      best_r <= best_nxt;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.exec || cmd.pop) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status_r <= ((op_r == OP_PUSH) && !push_ok) ? STS_DROP : STS_OK;
      out_value_r  <= '0;
    end else if (cmd.pop) begin
      out_status_r <= best_r.vld ? STS_OK : STS_EMPTY;
      out_value_r  <= best_r.vld ? best_r.val : '0;
    end
  end

  assign sts.op       = op_r;
  assign sts.out_free = out_free;
  assign sts.refill   = refill;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

endmodule

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kwm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int ITEM_TARGET = 1650;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int VMAX = 32'sh7fffffff;
  localparam int VMIN = 32'sh80000000;

  typedef struct {
    op_t                     op;
    logic [LIDX_W-1:0]       list_index;
    logic signed [VAL_W-1:0] value;
  } merge_op_t;

  typedef struct {
    status_t                 status;
    logic signed [VAL_W-1:0] value;
  } merge_result_t;

  logic clk = 1'b0;
  logic rst_n;

  kwm_in_if  in_if ();
  kwm_out_if out_if ();

  k_way_sorted_merge_unit uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the list fifos
  logic signed [VAL_W-1:0] list_mem [LISTS][DEPTH];
  int                      rd_ptr [LISTS];
  int                      wr_ptr [LISTS];
  logic signed [VAL_W-1:0] head_val [LISTS];

  merge_op_t     pending_ops[$];
  merge_result_t pending_results[$];

  int accepted_cnt = 0;
  int quiet_from = 0;
  int mismatches = 0;
  int results_seen = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int src_gap = 0;
  int sink_gap = 0;

  function automatic int list_fill(input int l);
    return (wr_ptr[l] + 2 * DEPTH - rd_ptr[l]) % (2 * DEPTH);
  endfunction

  function automatic merge_result_t merge_next(input merge_op_t it);
    merge_result_t r;
    int            l;
    int            best;
    r.status = STS_OK;
    r.value  = '0;
    best     = -1;
    case (it.op)
      OP_PUSH: begin
        l = int'(it.list_index);
        if (l >= LISTS || list_fill(l) >= DEPTH) begin
          r.status = STS_DROP;
        end else begin
          if (list_fill(l) == 0) begin
            head_val[l] = it.value;
          end
          list_mem[l][wr_ptr[l] % DEPTH] = it.value;
          wr_ptr[l] = (wr_ptr[l] + 1) % (2 * DEPTH);
        end
      end
      OP_POP: begin
        for (l = 0; l < LISTS; l++) begin
          if (list_fill(l) != 0 && (best < 0 || head_val[l] < head_val[best])) begin
            best = l;
          end
        end
        if (best < 0) begin
          r.status = STS_EMPTY;
        end else begin
          r.value = head_val[best];
          rd_ptr[best] = (rd_ptr[best] + 1) % (2 * DEPTH);
          if (list_fill(best) != 0) begin
            head_val[best] = list_mem[best][rd_ptr[best] % DEPTH];
          end
        end
      end
      OP_CLEAR: begin
        for (l = 0; l < LISTS; l++) begin
          rd_ptr[l] = 0;
          wr_ptr[l] = 0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_op(input op_t op, input int idx, input int val);
    merge_op_t it;
    it.op         = op;
    it.list_index = LIDX_W'(idx);
    it.value      = val;
    pending_ops.push_back(it);
  endtask

  // small values give lots of ties, others spread over the whole range or sit near the extremes
  function automatic int pick_value(input int mode);
    case (mode)
      0:       return $urandom_range(0, 8) - 4;
      1:       return $urandom;
      default: return ($urandom_range(0, 1) != 0) ? VMAX - $urandom_range(0, 3)
                                                  : VMIN + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic queue_run(input int l, input int count, input int mode);
    longint cur;
    int     k;
    cur = pick_value(mode);
    for (k = 0; k < count; k++) begin
      queue_op(OP_PUSH, l, int'(cur));
      cur = cur + ((mode == 0) ? $urandom_range(0, 2) : $urandom_range(0, 1000000));
      if (cur > VMAX) begin
        cur = VMAX;
      end
    end
  endtask

  task automatic build_random_part();
    int r;
    int n;
    int k;
    int held;
    int fills;
    fills = 0;
    while (pending_ops.size() < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if ((r < 6 || fills == 0) && fills < 5) begin
        // fill one list past full, then drain it
        n = $urandom_range(12, 15);
        queue_run(n, DEPTH + $urandom_range(1, 3), $urandom_range(0, 1));
        for (k = 0; k < DEPTH + $urandom_range(0, 2); k++) begin
          queue_op(OP_POP, $urandom_range(0, 15), $urandom);
        end
        fills++;
      end else if (r < 76) begin
        held = 0;
        for (n = $urandom_range(1, 6); n > 0; n--) begin
          k = $urandom_range(1, 8);
          queue_run($urandom_range(0, 15), k, $urandom_range(0, 2));
          held += k;
          if ($urandom_range(0, 3) == 0) begin
            queue_op(OP_POP, $urandom_range(0, 15), $urandom);
          end
        end
        for (k = $urandom_range(held / 2, held + 2); k > 0; k--) begin
          queue_op(OP_POP, $urandom_range(0, 15), $urandom);
        end
      end else if (r < 80) begin
        queue_op(OP_CLEAR, $urandom_range(0, 15), $urandom);
        if ($urandom_range(0, 1) != 0) begin
          queue_op(OP_POP, $urandom_range(0, 15), $urandom);
        end
      end else if (r < 84) begin
        queue_op(OP_NOP, $urandom_range(0, 15), $urandom);
      end else begin
        queue_op(op_t'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom);
      end
    end
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch in %s at result %0d: got %0d, want %0d",
             field, results_seen, got, want);
    mismatches++;
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OP_NOP;
    in_if.list_index = '0;
    in_if.value = '0;
    out_if.ready = 1'b0;
    for (int l = 0; l < LISTS; l++) begin
      rd_ptr[l]   = 0;
      wr_ptr[l]   = 0;
      head_val[l] = '0;
    end

    // empty pop, extremes, ties across lists and within a list
    queue_op(OP_POP, 0, 0);
    queue_op(OP_PUSH, 5, VMAX);
    queue_op(OP_PUSH, 3, VMIN);
    queue_op(OP_PUSH, 0, 0);
    queue_op(OP_PUSH, 15, 0);
    queue_op(OP_PUSH, 7, -1);
    queue_op(OP_PUSH, 2, 5);
    queue_op(OP_PUSH, 9, 5);
    queue_op(OP_PUSH, 7, -1);
    for (int k = 0; k < 9; k++) begin
      queue_op(OP_POP, 15 - k, -1);
    end
    queue_op(OP_NOP, 15, -1);
    queue_op(OP_PUSH, 4, 123);
    queue_op(OP_CLEAR, 10, VMAX);
    queue_op(OP_POP, 4, 0);
    queue_op(OP_PUSH, 1, 77);
    queue_op(OP_POP, 1, 0);

    build_random_part();
    quiet_from = pending_ops.size() * 85 / 100;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // sender
  always @(posedge clk) begin : drive_in
    bit taken;
    taken = 1'b0;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        pending_results.push_back(merge_next(pending_ops.pop_front()));
        accepted_cnt <= accepted_cnt + 1;
        taken = 1'b1;
      end
      // a beat on offer stays unchanged until taken
      if (!in_if.valid || taken) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (accepted_cnt < quiet_from && $urandom_range(0, 11) == 0) begin
          src_gap = $urandom_range(1, 13);
        end
        if (src_gap == 0 && pending_ops.size() > 0) begin
          in_if.valid      <= 1'b1;
          in_if.op         <= pending_ops[0].op;
          in_if.list_index <= pending_ops[0].list_index;
          in_if.value      <= pending_ops[0].value;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && accepted_cnt >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (sink_gap > 0) begin
        sink_gap--;
      end else if (accepted_cnt < quiet_from && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(1, 13);
      end
      out_if.ready <= (sink_gap == 0) && (hold_left == 0);
    end
  end

  // result checker
  always @(posedge clk) begin : check_out
    merge_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat status", out_if.status, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_if.status !== want.status) begin
          report_mismatch("status", out_if.status, want.status);
        end
        if (out_if.out_value !== want.value) begin
          report_mismatch("out_value", out_if.out_value, want.value);
        end
      end
      results_seen <= results_seen + 1;
    end
  end

endmodule
